[rtl/core/frsn_pkg.sv]
// frsn_pkg: shared constants and the word type carried along the cell chain.
// No dependencies; imported by every module of the renumber table core.
`timescale 1ns / 1ps

package frsn_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ID_W        = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 4;

   // register index taken from the byte address (8-byte spacing)
   localparam logic REG_ID_BASE = 1'b0;

   localparam logic signed [ID_W-1:0] ID_BASE_RESET = ID_W'(1);

   // one word travelling down the chain
   typedef struct packed {
      logic             vld;
      logic [ID_W-1:0]  key;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } frsn_word_type;

endpackage

[rtl/core/first_seen_id_renumber_table_core.sv]
// first_seen_id_renumber_table_core: renumbers IDs densely by first appearance.
// A req word passes each cell register in turn, then the output register, to rsp_valid.
// Throughput: one word per advancing cycle; words stream through the chain back to back.
// Back-pressure on rsp freezes the whole chain. Depends on frsn_pkg, frsn_cell, frsn_out.
// Reset (synchronous): table empty, fill count 0, id base 1, chain and output empty.
`timescale 1ns / 1ps

module first_seen_id_renumber_table_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [frsn_pkg::ID_W-1:0]       req_old_id,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [frsn_pkg::ID_W-1:0]       rsp_new_id,
   output logic                                   rsp_table_full,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [frsn_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [frsn_pkg::ID_W-1:0]              pwdata,
   output logic [frsn_pkg::ID_W-1:0]              prdata,
   output logic                                   pready
);
   import frsn_pkg::*;

   // Each cell owns one slot. A word enters cell 0 and moves one cell per
   // advancing cycle. Slots fill in order, so slot k holds an ID exactly when
   // k < fill count; no per-slot valid bit is kept. A word that has not hit by
   // the time it meets the first empty slot claims it. Later words are always
   // behind, so they reach that slot after it is written and compare against it.
   // A word leaving the last cell without a hit means the table is full.

   logic signed [ID_W-1:0]  id_base_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    advance;
   logic [TABLE_DEPTH-1:0]  claim_vec;
   frsn_word_type           chain [0:TABLE_DEPTH];

   // --- register port: 64-bit data, id base at byte address 0
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff <= ID_BASE_RESET;
      end else if (psel && penable && pwrite && (paddr[3] == REG_ID_BASE)) begin
         id_base_ff <= pwdata;
      end
   end

   always_comb begin
      case (paddr[3])
         REG_ID_BASE: prdata = id_base_ff;
         default:     prdata = '0;
      endcase
   end

   // --- chain entry
   assign req_ready = advance;

   assign chain[0] = {req_valid, req_old_id, 1'b0, {IDX_W{1'b0}}};

   // --- the row of cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      frsn_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_idx   (IDX_W'(g)),
         .fill_count (count_ff),
         .word_i     (chain[g]),
         .word_o     (chain[g+1]),
         .claim      (claim_vec[g])
      );
   end

   // at most one cell claims per cycle
   assign count_in = count_ff + CNT_W'(|claim_vec);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // --- offset and output register
   frsn_out u_out (
      .clock          (clock),
      .reset          (reset),
      .word_i         (chain[TABLE_DEPTH]),
      .id_base        (id_base_ff),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_id     (rsp_new_id),
      .rsp_table_full (rsp_table_full)
   );

endmodule

[rtl/core/frsn_cell.sv]
// frsn_cell: one table slot plus one chain stage; compares or claims as a word passes.
// Depends on frsn_pkg.
`timescale 1ns / 1ps

module frsn_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [frsn_pkg::IDX_W-1:0] cell_idx,
   input  logic [frsn_pkg::CNT_W-1:0] fill_count,
   input  frsn_pkg::frsn_word_type word_i,
   output frsn_pkg::frsn_word_type word_o,
   output logic                    claim
);
   import frsn_pkg::*;

   logic [ID_W-1:0] stored_ff;
   frsn_word_type   word_ff;
   frsn_word_type   word_in;
   logic            live;
   logic            free;
   logic            hit_here;

   always_comb begin
      live     = CNT_W'(cell_idx) < fill_count;
      free     = CNT_W'(cell_idx) == fill_count;
      hit_here = word_i.vld && !word_i.hit && live && (stored_ff == word_i.key);
      claim    = advance && word_i.vld && !word_i.hit && free;
      word_in  = word_i;
      if (hit_here || claim) begin
         word_in.hit = 1'b1;
         word_in.idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else if (advance) begin
         word_ff.vld <= word_in.vld;
      end
      if (advance) begin
         word_ff.key <= word_in.key;
         word_ff.hit <= word_in.hit;
         word_ff.idx <= word_in.idx;
      end
      if (claim) begin
         stored_ff <= word_i.key;
      end
   end

   assign word_o = word_ff;

endmodule

[rtl/core/frsn_out.sv]
// frsn_out: output register; applies the start offset and flags a full table.
// Depends on frsn_pkg.
`timescale 1ns / 1ps

module frsn_out (
   input  logic                              clock,
   input  logic                              reset,
   input  frsn_pkg::frsn_word_type           word_i,
   input  logic signed [frsn_pkg::ID_W-1:0]  id_base,
   output logic                              advance,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [frsn_pkg::ID_W-1:0]  rsp_new_id,
   output logic                              rsp_table_full
);
   import frsn_pkg::*;

   logic                   vld_ff;
   logic signed [ID_W-1:0] new_id_ff;
   logic signed [ID_W-1:0] new_id_in;
   logic                   full_ff;
   logic [ID_W-1:0]        dense_k;

   assign advance = !vld_ff || rsp_ready;

   // dense number n = idx + 1; n+start-1 = start+idx, start+1-n = start-idx
   always_comb begin
      dense_k = ID_W'(word_i.idx);
      if (!word_i.hit) begin
         new_id_in = '0;
      end else if (id_base[ID_W-1]) begin
         new_id_in = id_base - $signed(dense_k);
      end else begin
         new_id_in = id_base + $signed(dense_k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= word_i.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         new_id_ff <= new_id_in;
         full_ff   <= !word_i.hit;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_new_id     = new_id_ff;
   assign rsp_table_full = full_ff;

endmodule
